FILE: sv/gpsbcd_pkg.sv
package gpsbcd_pkg;

   localparam int STAGES = 9;

   localparam logic [63:0] DEG_RECIP  = 64'd3602879702;
   localparam logic [63:0] MIN_RECIP  = 64'd450359963;
   localparam logic [47:0] FRAC_RECIP = 48'd17179870;
   localparam logic [29:0] V_RECIP    = 30'd26844;
   localparam logic [63:0] DM_RECIP   = 64'd214748365;
   localparam logic [63:0] ALT_RECIP  = 64'd27487791;
   localparam logic [31:0] HDOP_RECIP = 32'd52429;
   localparam logic [26:0] HUN_RECIP  = 27'd5243;
   localparam logic [14:0] TEN_RECIP  = 15'd205;

   localparam logic [31:0] DEG_SCALE  = 32'd10000000;
   localparam logic [6:0]  HDOP_MAX   = 7'd99;

   localparam logic [7:0] FLAG_NORTH       = 8'h01;
   localparam logic [7:0] FLAG_EAST        = 8'h02;
   localparam logic [7:0] FLAG_LON_OVER_99 = 8'h04;
   localparam logic [7:0] FLAG_FIX         = 8'h08;
   localparam logic [7:0] FLAG_DATA        = 8'h10;
   localparam logic [7:0] FLAG_3D          = 8'h20;
   localparam logic [7:0] FLAG_NEG_ALT     = 8'h80;

   typedef struct packed {
      logic [STAGES-1:0] adv;
   } pipe_ctl_type;

endpackage

FILE: sv/gpsbcd_coord.sv
module gpsbcd_coord (
   input  logic                      clock,
   input  gpsbcd_pkg::pipe_ctl_type  ctl,
   input  logic [31:0]               mag,
   output logic [13:0]               deg_min,
   output logic [13:0]               frac
);
   import gpsbcd_pkg::*;

   logic [31:0] mag1_ff;
   logic [7:0]  deg1_ff, deg2_ff, deg3_ff;
   logic [29:0] rem2_ff, rem3_ff;
   logic [5:0]  min3_ff;
   logic [23:0] fx4_ff;
   logic [14:0] v4_ff, v5_ff;
   logic [13:0] frac5_ff, frac6_ff, v6_ff;
   logic [1:0]  vq5_ff;

   logic [63:0] deg_p, min_p;
   logic [47:0] frac_p;
   logic [29:0] vq_p;
   logic [31:0] r_in;
   logic [29:0] rem2_in, fx_in;
   logic [14:0] v6_in;

   always_comb begin
      deg_p   = 64'(mag) * DEG_RECIP;
      r_in    = mag1_ff - 32'(deg1_ff) * DEG_SCALE;
      rem2_in = 30'(r_in[23:0]) * 30'd60;
      min_p   = 64'(rem2_ff) * MIN_RECIP;
      fx_in   = rem3_ff - 30'(min3_ff) * 30'(DEG_SCALE);
      frac_p  = 48'(fx4_ff) * FRAC_RECIP;
      vq_p    = 30'(v4_ff) * V_RECIP;
      v6_in   = v5_ff - 15'(vq5_ff) * 15'd10000;
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         mag1_ff <= mag;
         deg1_ff <= deg_p[62:55];
      end
      if (ctl.adv[2]) begin
         rem2_ff <= rem2_in;
         deg2_ff <= deg1_ff;
      end
      if (ctl.adv[3]) begin
         rem3_ff <= rem2_ff;
         min3_ff <= min_p[57:52];
         deg3_ff <= deg2_ff;
      end
      if (ctl.adv[4]) begin
         fx4_ff <= fx_in[23:0];
         v4_ff  <= 15'(deg3_ff) * 15'd100 + 15'(min3_ff);
      end
      if (ctl.adv[5]) begin
         frac5_ff <= frac_p[47:34];
         vq5_ff   <= vq_p[29:28];
         v5_ff    <= v4_ff;
      end
      if (ctl.adv[6]) begin
         frac6_ff <= frac5_ff;
         v6_ff    <= v6_in[13:0];
      end
   end

   assign deg_min = v6_ff;
   assign frac    = frac6_ff;

endmodule

FILE: sv/gpsbcd_bcd4.sv
module gpsbcd_bcd4 (
   input  logic                      clock,
   input  gpsbcd_pkg::pipe_ctl_type  ctl,
   input  logic [13:0]               value,
   output logic [15:0]               bcd
);
   import gpsbcd_pkg::*;

   logic [6:0]  hi_ff, lo_ff;
   logic [15:0] bcd_ff;
   logic [26:0] hun_p;
   logic [13:0] lo_in;
   logic [14:0] th_p, tl_p;
   logic [3:0]  th, tl;
   logic [6:0]  oh, ol;

   always_comb begin
      hun_p = 27'(value) * HUN_RECIP;
      lo_in = value - 14'(hun_p[25:19]) * 14'd100;
      th_p  = 15'(hi_ff) * TEN_RECIP;
      tl_p  = 15'(lo_ff) * TEN_RECIP;
      th    = th_p[14:11];
      tl    = tl_p[14:11];
      oh    = hi_ff - 7'(th) * 7'd10;
      ol    = lo_ff - 7'(tl) * 7'd10;
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[7]) begin
         hi_ff <= hun_p[25:19];
         lo_ff <= lo_in[6:0];
      end
      if (ctl.adv[8]) begin
         bcd_ff <= {th, oh[3:0], tl, ol[3:0]};
      end
   end

   assign bcd = bcd_ff;

endmodule

FILE: sv/gps_location_bcd_encoder_core.sv
// GPS location record encoder.
// A request on the req_ channel carries one fix: latitude and longitude in
// degrees times ten million, altitude in centimeters, course, HDOP, satellite
// count and the enable and fix flags. Each request gives exactly one response
// on the rsp_ channel with packed BCD fields and a flag byte. When the fix is
// unusable the response has rsp_frame_valid low and all other fields zero.
// A request is taken at an edge where req_valid is high and req_stall is low;
// a response is taken where rsp_valid is high and rsp_stall is low.
// The datapath is a nine stage pipeline. A taken request moves through the stage
// registers in order, and rsp_valid is the valid bit of the last stage; one
// request can be taken every cycle while req_stall is low.
// The divisions by constants are reciprocal multiplies.
// When rsp_stall is high the pipeline first fills its empty stages and then
// raises req_stall; nothing is lost or repeated.
// The csr_ channel writes min_satellites and is always ready; write it only
// while the pipeline is empty. Synchronous reset empties the pipeline and sets
// min_satellites to 6.
module gps_location_bcd_encoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_latitude,
   input  logic signed [31:0] req_longitude,
   input  logic signed [27:0] req_altitude_cm,
   input  logic [11:0]        req_ground_course,
   input  logic [15:0]        req_hdop_raw,
   input  logic [7:0]         req_satellite_count,
   input  logic               req_gps_enabled,
   input  logic               req_fix_present,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_valid,
   output logic [15:0]        rsp_altitude_bcd,
   output logic [31:0]        rsp_latitude_bcd,
   output logic [31:0]        rsp_longitude_bcd,
   output logic [15:0]        rsp_course_bcd,
   output logic [7:0]         rsp_hdop_bcd,
   output logic [7:0]         rsp_gps_flags,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);
   import gpsbcd_pkg::*;

   logic [7:0]        min_sats_ff;
   logic [STAGES-1:0] vld_ff;
   pipe_ctl_type      ctl;

   logic [31:0] lat_mag0_ff, lon_mag0_ff;
   logic [27:0] alt_mag0_ff;
   logic [23:0] dm1_ff, dm2_ff;
   logic [10:0] aq2_ff;
   logic [13:0] av_ff [3:6];
   logic [11:0] course_ff [0:6];
   logic [6:0]  hdop_ff [0:6];
   logic [7:0]  flags_ff [0:8];
   logic        ok_ff [0:8];

   logic [31:0] lat_abs, lon_abs;
   logic [27:0] alt_abs;
   logic [31:0] hdop_p;
   logic [63:0] dm_p, aq_p;
   logic [23:0] av_in;
   logic [7:0]  flags_in;
   logic        ok_in;

   logic [13:0] lat_dm, lat_fr, lon_dm, lon_fr;
   logic [13:0] alt_x, course_x, hdop_x, lat_dm_x, lat_fr_x, lon_dm_x, lon_fr_x;
   logic [15:0] alt_b, course_b, hdop_b, lat_dm_b, lat_fr_b, lon_dm_b, lon_fr_b;

   always_comb begin
      ctl.adv[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ctl.adv[i] = !vld_ff[i] || ctl.adv[i+1];
      end
   end

   assign req_stall = !ctl.adv[0];
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         min_sats_ff <= 8'd6;
      end else begin
         if (csr_valid) begin
            min_sats_ff <= csr_data;
         end
         if (ctl.adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (ctl.adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_comb begin
      lat_abs = req_latitude[30] ? 32'(-33'(req_latitude)) : 32'(req_latitude);
      lon_abs = req_longitude[31] ? 32'(-33'(req_longitude)) : 32'(req_longitude);
      alt_abs = req_altitude_cm[27] ? 28'(-29'(req_altitude_cm)) : 28'(req_altitude_cm);
      hdop_p  = 32'(req_hdop_raw) * HDOP_RECIP;
      ok_in   = req_gps_enabled && req_fix_present && (req_satellite_count >= min_sats_ff);
      flags_in = FLAG_DATA | FLAG_FIX | FLAG_3D;
      if (!req_latitude[30] && (req_latitude != '0)) begin
         flags_in = flags_in | FLAG_NORTH;
      end
      if (!req_longitude[31] && (req_longitude != '0)) begin
         flags_in = flags_in | FLAG_EAST;
      end
      if (req_altitude_cm[27]) begin
         flags_in = flags_in | FLAG_NEG_ALT;
      end
      if (lon_abs >= 32'd1000000000) begin
         flags_in = flags_in | FLAG_LON_OVER_99;
      end
      dm_p  = 64'(alt_mag0_ff) * DM_RECIP;
      aq_p  = 64'(dm1_ff) * ALT_RECIP;
      av_in = dm2_ff - 24'(aq2_ff) * 24'd10000;
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         lat_mag0_ff  <= lat_abs;
         lon_mag0_ff  <= lon_abs;
         alt_mag0_ff  <= alt_abs;
         course_ff[0] <= req_ground_course;
         hdop_ff[0]   <= (hdop_p[31:19] > 13'(HDOP_MAX)) ? HDOP_MAX : hdop_p[25:19];
         flags_ff[0]  <= flags_in;
         ok_ff[0]     <= ok_in;
      end
      if (ctl.adv[1]) begin
         dm1_ff <= dm_p[54:31];
      end
      if (ctl.adv[2]) begin
         dm2_ff <= dm1_ff;
         aq2_ff <= aq_p[48:38];
      end
      if (ctl.adv[3]) begin
         av_ff[3] <= av_in[13:0];
      end
      for (int i = 4; i <= 6; i++) begin
         if (ctl.adv[i]) begin
            av_ff[i] <= av_ff[i-1];
         end
      end
      for (int i = 1; i <= 6; i++) begin
         if (ctl.adv[i]) begin
            course_ff[i] <= course_ff[i-1];
            hdop_ff[i]   <= hdop_ff[i-1];
         end
      end
      for (int i = 1; i <= 8; i++) begin
         if (ctl.adv[i]) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
      for (int i = 1; i <= 8; i++) begin
         if (ctl.adv[i]) begin
            ok_ff[i] <= ok_ff[i-1];
         end
      end
   end

   gpsbcd_coord u_lat (
      .clock   (clock),
      .ctl     (ctl),
      .mag     (lat_mag0_ff),
      .deg_min (lat_dm),
      .frac    (lat_fr)
   );

   gpsbcd_coord u_lon (
      .clock   (clock),
      .ctl     (ctl),
      .mag     (lon_mag0_ff),
      .deg_min (lon_dm),
      .frac    (lon_fr)
   );

   // An unusable fix is zeroed before the digit split, so its fields come out zero.
   always_comb begin
      alt_x    = ok_ff[6] ? av_ff[6] : '0;
      course_x = ok_ff[6] ? 14'(course_ff[6]) : '0;
      hdop_x   = ok_ff[6] ? 14'(hdop_ff[6]) : '0;
      lat_dm_x = ok_ff[6] ? lat_dm : '0;
      lat_fr_x = ok_ff[6] ? lat_fr : '0;
      lon_dm_x = ok_ff[6] ? lon_dm : '0;
      lon_fr_x = ok_ff[6] ? lon_fr : '0;
   end

   gpsbcd_bcd4 u_alt_b (.clock(clock), .ctl(ctl), .value(alt_x), .bcd(alt_b));
   gpsbcd_bcd4 u_crs_b (.clock(clock), .ctl(ctl), .value(course_x), .bcd(course_b));
   gpsbcd_bcd4 u_hdp_b (.clock(clock), .ctl(ctl), .value(hdop_x), .bcd(hdop_b));
   gpsbcd_bcd4 u_lad_b (.clock(clock), .ctl(ctl), .value(lat_dm_x), .bcd(lat_dm_b));
   gpsbcd_bcd4 u_laf_b (.clock(clock), .ctl(ctl), .value(lat_fr_x), .bcd(lat_fr_b));
   gpsbcd_bcd4 u_lod_b (.clock(clock), .ctl(ctl), .value(lon_dm_x), .bcd(lon_dm_b));
   gpsbcd_bcd4 u_lof_b (.clock(clock), .ctl(ctl), .value(lon_fr_x), .bcd(lon_fr_b));

   assign rsp_frame_valid   = ok_ff[8];
   assign rsp_altitude_bcd  = alt_b;
   assign rsp_course_bcd    = course_b;
   assign rsp_hdop_bcd      = hdop_b[7:0] | {8{|hdop_b[15:8]}};
   assign rsp_latitude_bcd  = {lat_dm_b, lat_fr_b};
   assign rsp_longitude_bcd = {lon_dm_b, lon_fr_b};
   assign rsp_gps_flags     = ok_ff[8] ? flags_ff[8] : '0;

endmodule

FILE: sv/gpsbcd_checker.sv
module gpsbcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_frame_valid,
   input logic [15:0] rsp_altitude_bcd,
   input logic [31:0] rsp_latitude_bcd,
   input logic [31:0] rsp_longitude_bcd,
   input logic [15:0] rsp_course_bcd,
   input logic [7:0]  rsp_hdop_bcd,
   input logic [7:0]  rsp_gps_flags
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_valid |-> (rsp_altitude_bcd == '0) && (rsp_latitude_bcd == '0)
      && (rsp_longitude_bcd == '0) && (rsp_course_bcd == '0) && (rsp_hdop_bcd == '0)
      && (rsp_gps_flags == '0))
      else $error("invalid record has nonzero fields");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> (rsp_gps_flags[5:3] == 3'b111) && !rsp_gps_flags[6]
      && (rsp_hdop_bcd[7:4] <= 4'd9))
      else $error("bad flag byte or hdop in valid record");

endmodule

bind gps_location_bcd_encoder_core gpsbcd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_valid   (rsp_frame_valid),
   .rsp_altitude_bcd  (rsp_altitude_bcd),
   .rsp_latitude_bcd  (rsp_latitude_bcd),
   .rsp_longitude_bcd (rsp_longitude_bcd),
   .rsp_course_bcd    (rsp_course_bcd),
   .rsp_hdop_bcd      (rsp_hdop_bcd),
   .rsp_gps_flags     (rsp_gps_flags)
);
